// ----- rtl/core/rpi_pkg.sv -----
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared widths and the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int CW   = 32;             // coordinate width
    localparam int FB   = 16;             // fraction bits
    localparam int TW   = CW - 1;         // ray parameter width
    localparam int PW   = 2 * CW;         // exact product width
    localparam int DW   = PW + 2;         // dot product width
    localparam int NW   = PW + 3;         // numerator width
    localparam int RW   = DW + CW + FB;   // divider remainder width
    localparam int QD   = 4;              // queue depth
    localparam int QAW  = $clog2(QD);
    localparam int QCW  = $clog2(QD + 1);

    typedef logic [2:0][CW-1:0] vec3_t;

    typedef struct packed {
        logic          miss;
        logic          sat;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        vec3_t         org;
        vec3_t         dir;
    } rpi_job_t;

endpackage

// ----- rtl/core/rpi_front.sv -----
// ----------------------------------------------------------------------------
// rpi_front
// Dot products, numerator and hit classification; emits one job per transfer.
// ----------------------------------------------------------------------------
module rpi_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rpi_pkg::vec3_t    org,
    input  rpi_pkg::vec3_t    dir,
    input  rpi_pkg::vec3_t    nrm,
    input  logic [rpi_pkg::CW-1:0] off,
    output logic              push,
    output rpi_pkg::rpi_job_t job,
    output logic [1:0]        inflight
);
    import rpi_pkg::*;

    logic va_reg, vb_reg, vc_reg;
    logic signed [PW-1:0] pnd_reg [3];
    logic signed [PW-1:0] pns_reg [3];
    vec3_t orga_reg, dira_reg;
    logic [CW-1:0] offa_reg;
    rpi_job_t jobb_reg, jobc_reg;
    rpi_job_t jobb_next, jobc_next;
    logic signed [DW-1:0] d1_next;
    logic signed [NW-1:0] num_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pnd_reg[i] <= $signed(nrm[i]) * $signed(dir[i]);
            pns_reg[i] <= $signed(nrm[i]) * $signed(org[i]);
        end
        orga_reg <= org;
        dira_reg <= dir;
        offa_reg <= off;
        jobb_reg <= jobb_next;
        jobc_reg <= jobc_next;
    end

    always_comb
    begin
        d1_next  = DW'(pnd_reg[0]) + DW'(pnd_reg[1]) + DW'(pnd_reg[2]);
        num_next = NW'(pns_reg[0]) + NW'(pns_reg[1]) + NW'(pns_reg[2])
                 - (NW'($signed(offa_reg)) <<< FB);
        jobb_next.miss = !d1_next[DW-1] || num_next[NW-1];
        jobb_next.sat  = 1'b0;
        jobb_next.num  = num_next;
        jobb_next.den  = -d1_next;
        jobb_next.org  = orga_reg;
        jobb_next.dir  = dira_reg;

        jobc_next     = jobb_reg;
        jobc_next.sat = (RW'(jobb_reg.num) << FB) >= (RW'(jobb_reg.den) << TW);
    end

    assign push     = vc_reg;
    assign job      = jobc_reg;
    assign inflight = {1'b0, va_reg} + {1'b0, vb_reg} + {1'b0, vc_reg};

endmodule

// ----- rtl/core/rpi_queue.sv -----
// ----------------------------------------------------------------------------
// rpi_queue
// Small job queue between front end and back end.
// ----------------------------------------------------------------------------
module rpi_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rpi_pkg::rpi_job_t din,
    input  logic              pop,
    output rpi_pkg::rpi_job_t dout,
    output logic              empty,
    output logic [rpi_pkg::QCW-1:0] count
);
    import rpi_pkg::*;

    rpi_job_t mem_reg [QD];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCW'(1);
        else if (pop && !push)
            count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCW'(QD)) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCW'(1))
        else $error("queue count mismatch");

endmodule

// ----- rtl/core/rpi_back.sv -----
// ----------------------------------------------------------------------------
// rpi_back
// Pipelined restoring divider for t, then hit point multiply and saturation.
// ----------------------------------------------------------------------------
module rpi_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rpi_pkg::rpi_job_t job,
    output logic              done,
    output logic              hit,
    output logic [rpi_pkg::TW-1:0] ray_param,
    output rpi_pkg::vec3_t    point
);
    import rpi_pkg::*;

    logic           v_reg    [TW+1];
    logic [RW-1:0]  r_reg    [TW+1];
    logic [DW-1:0]  den_reg  [TW+1];
    logic [TW-1:0]  q_reg    [TW+1];
    logic           miss_reg [TW+1];
    logic           sat_reg  [TW+1];
    vec3_t          org_reg  [TW+1];
    vec3_t          dir_reg  [TW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= RW'(job.num) << FB;
        den_reg[0]  <= job.den;
        q_reg[0]    <= '0;
        miss_reg[0] <= job.miss;
        sat_reg[0]  <= job.sat;
        org_reg[0]  <= job.org;
        dir_reg[0]  <= job.dir;
    end

    for (genvar s = 0; s < TW; s++)
    begin : g_div
        localparam int B = TW - 1 - s;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(den_reg[s]) << B;
        assign ge  = r_reg[s] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            r_reg[s+1]    <= ge ? r_reg[s] - dsh : r_reg[s];
            q_reg[s+1]    <= {q_reg[s][TW-2:0], ge};
            den_reg[s+1]  <= den_reg[s];
            miss_reg[s+1] <= miss_reg[s];
            sat_reg[s+1]  <= sat_reg[s];
            org_reg[s+1]  <= org_reg[s];
            dir_reg[s+1]  <= dir_reg[s];
        end
    end

    logic                 vm_reg, mmiss_reg;
    logic [TW-1:0]        tm_reg, t_next;
    logic signed [PW-1:0] prod_reg [3];
    vec3_t                morg_reg;

    assign t_next = sat_reg[TW] ? '1 : q_reg[TW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= v_reg[TW];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= $signed({1'b0, t_next}) * $signed(dir_reg[TW][i]);
        tm_reg    <= t_next;
        mmiss_reg <= miss_reg[TW];
        morg_reg  <= org_reg[TW];
    end

    logic signed [PW:0] sum [3];
    vec3_t              pt_next;
    logic               done_reg, hit_reg;
    logic [TW-1:0]      t_reg;
    vec3_t              pt_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = (PW+1)'(prod_reg[i] >>> FB) + (PW+1)'($signed(morg_reg[i]));
            if (sum[i][PW:CW-1] == '0 || sum[i][PW:CW-1] == '1)
                pt_next[i] = sum[i][CW-1:0];
            else if (sum[i][PW])
                pt_next[i] = {1'b1, {(CW-1){1'b0}}};
            else
                pt_next[i] = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= !mmiss_reg;
        t_reg   <= mmiss_reg ? '0 : tm_reg;
        pt_reg  <= mmiss_reg ? '0 : pt_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign ray_param = t_reg;
    assign point     = pt_reg;

endmodule

// ----- rtl/core/ray_plane_intersection.sv -----
// ----------------------------------------------------------------------------
// ray_plane_intersection
// Ray against plane in signed Q16.16: hit flag, ray parameter, hit point.
// Throughput: one transfer per cycle unless busy; the 31-stage divider sets depth.
// busy rises only if the job queue could overflow; with no output stall it stays low.
// Reset (rst_n, async) clears all valid bits and queue pointers.
// ----------------------------------------------------------------------------
module ray_plane_intersection
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rpi_pkg::CW-1:0]       start_x,
    input  logic [rpi_pkg::CW-1:0]       start_y,
    input  logic [rpi_pkg::CW-1:0]       start_z,
    input  logic [rpi_pkg::CW-1:0]       dir_x,
    input  logic [rpi_pkg::CW-1:0]       dir_y,
    input  logic [rpi_pkg::CW-1:0]       dir_z,
    input  logic [rpi_pkg::CW-1:0]       normal_x,
    input  logic [rpi_pkg::CW-1:0]       normal_y,
    input  logic [rpi_pkg::CW-1:0]       normal_z,
    input  logic [rpi_pkg::CW-1:0]       plane_offset,
    output logic                         done,
    output logic                         hit,
    output logic [rpi_pkg::TW-1:0]       ray_param,
    output logic [rpi_pkg::CW-1:0]       point_x,
    output logic [rpi_pkg::CW-1:0]       point_y,
    output logic [rpi_pkg::CW-1:0]       point_z
);
    import rpi_pkg::*;

    logic       accept, push, pop, empty;
    logic [1:0] inflight;
    logic [QCW-1:0] count;
    rpi_job_t   fjob, qjob;
    vec3_t      org, dir, nrm, point;

    assign org = {start_z, start_y, start_x};
    assign dir = {dir_z, dir_y, dir_x};
    assign nrm = {normal_z, normal_y, normal_x};

    // entry being popped this cycle frees its slot
    assign busy   = (count + QCW'(inflight) - QCW'(pop)) >= QCW'(QD);
    assign accept = start && !busy;
    assign pop    = !empty;

    rpi_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .org      (org),
        .dir      (dir),
        .nrm      (nrm),
        .off      (plane_offset),
        .push     (push),
        .job      (fjob),
        .inflight (inflight)
    );

    rpi_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (fjob),
        .pop   (pop),
        .dout  (qjob),
        .empty (empty),
        .count (count)
    );

    rpi_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .job       (qjob),
        .done      (done),
        .hit       (hit),
        .ray_param (ray_param),
        .point     (point)
    );

    assign point_x = point[0];
    assign point_y = point[1];
    assign point_z = point[2];

endmodule
